FILE: rtl/clr_pkg.sv
// shared constants, types and command/status structs of the clipped line rasterizer
`default_nettype none
package clr_pkg;

	localparam int COORD_BITS = 16;
	// internal coordinate width: input or offset plus headroom for the sum and differences
	localparam int CW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
	localparam int EW = CW + 1;
	localparam int PW = 2 * CW;
	localparam int DIV_CNT_W = $clog2(PW + 1);

	localparam int PIX_W = 15;
	localparam int COLOR_W = 32;
	localparam int OFS_W = 16;
	localparam int CLIP_POS_W = 15;
	localparam int CLIP_SIZE_W = 16;

	localparam int IN_TDATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * PIX_W + COLOR_W + 7) / 8) * 8;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_OFS_H = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFS_V = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_WIDTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR = 3'd6;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_STEP = 1'b1;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [EW-1:0] err_t;

	typedef struct packed {
		logic       load;
		logic       step;
		logic       mul;
		logic       div_start;
		logic       apply;
		logic       reject;
		logic       finish;
		logic [1:0] clip_k;
	} dp_cmd_t;

	typedef struct packed {
		logic box_reject;
		logic horiz;
		logic clip_cond;
		logic clip_reject;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/clr_div.sv
// restoring divider on magnitudes, one quotient bit per cycle
`default_nettype none
module clr_div (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [clr_pkg::PW-1:0]  dividend,
	input  wire logic [clr_pkg::CW-1:0]  divisor,
	output logic                         busy,
	output logic [clr_pkg::PW-1:0]       quotient
);
	import clr_pkg::*;

	logic [CW:0]          rem_q;
	logic [PW-1:0]        quo_q;
	logic [CW-1:0]        dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;

	logic [CW:0]   shifted;
	logic [CW+1:0] diff;
	logic          ge;

	assign shifted = {rem_q[CW-1:0], quo_q[PW-1]};
	assign diff = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge = !diff[CW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= DIV_CNT_W'(PW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			busy_q <= (cnt_q != DIV_CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CW:0] : shifted;
			quo_q <= {quo_q[PW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: rtl/clr_ctrl.sv
// load sequencer: bounding box test, four row clips, line setup
`default_nettype none
module clr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_accept,
	input  wire logic              in_action,
	input  wire clr_pkg::dp_stat_t stat,
	output clr_pkg::dp_cmd_t       cmd,
	output logic                   idle
);
	import clr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BOX,
		S_CHK,
		S_MUL,
		S_DIVS,
		S_DIVW,
		S_APPLY,
		S_REJECT,
		S_FINISH
	} state_t;

	state_t     state_q;
	logic [1:0] k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept && in_action == ACT_LOAD) state_q <= S_BOX;
				end
				S_BOX: begin
					k_q <= '0;
					if (stat.box_reject) state_q <= S_REJECT;
					else if (stat.horiz) state_q <= S_FINISH;
					else state_q <= S_CHK;
				end
				S_CHK: begin
					if (stat.clip_cond) begin
						state_q <= stat.clip_reject ? S_REJECT : S_MUL;
					end else if (k_q == 2'd3) begin
						state_q <= S_FINISH;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_MUL: state_q <= S_DIVS;
				S_DIVS: state_q <= S_DIVW;
				S_DIVW: begin
					if (stat.div_done) state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (k_q == 2'd3) begin
						state_q <= S_FINISH;
					end else begin
						k_q <= k_q + 2'd1;
						state_q <= S_CHK;
					end
				end
				S_REJECT: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				S_FINISH: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.clip_k = k_q;
		cmd.load = (state_q == S_IDLE) && in_accept && (in_action == ACT_LOAD);
		cmd.step = (state_q == S_IDLE) && in_accept && (in_action == ACT_STEP);
		cmd.mul = (state_q == S_MUL);
		cmd.div_start = (state_q == S_DIVS);
		cmd.apply = (state_q == S_APPLY);
		cmd.reject = (state_q == S_REJECT) && stat.out_free;
		cmd.finish = (state_q == S_FINISH) && stat.out_free;
	end

	assign idle = (state_q == S_IDLE);

endmodule
`default_nettype wire

FILE: rtl/clr_dp.sv
// datapath: config registers, endpoint clipping, bresenham walker, output register
`default_nettype none
module clr_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire clr_pkg::dp_cmd_t                 cmd,
	output clr_pkg::dp_stat_t                     stat,
	input  wire logic signed [clr_pkg::COORD_BITS-1:0] start_x,
	input  wire logic signed [clr_pkg::COORD_BITS-1:0] start_y,
	input  wire logic signed [clr_pkg::COORD_BITS-1:0] end_x,
	input  wire logic signed [clr_pkg::COORD_BITS-1:0] end_y,
	input  wire logic                             cfg_we,
	input  wire logic [clr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [clr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             out_ready,
	output logic                                  out_valid,
	output logic                                  line_active,
	output logic                                  write_enable,
	output logic [clr_pkg::PIX_W-1:0]             pixel_x,
	output logic [clr_pkg::PIX_W-1:0]             pixel_y,
	output logic [clr_pkg::COLOR_W-1:0]           pixel_value,
	output logic                                  last
);
	import clr_pkg::*;

	// configuration
	logic signed [OFS_W-1:0] ofs_h_q, ofs_v_q;
	logic [CLIP_POS_W-1:0]   left_q, top_q;
	logic [CLIP_SIZE_W-1:0]  width_q, height_q;
	logic [COLOR_W-1:0]      color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_h_q <= '0;
			ofs_v_q <= '0;
			left_q <= '0;
			top_q <= '0;
			width_q <= '0;
			height_q <= '0;
			color_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFS_H: ofs_h_q <= cfg_data[OFS_W-1:0];
				REG_OFS_V: ofs_v_q <= cfg_data[OFS_W-1:0];
				REG_CLIP_LEFT: left_q <= cfg_data[CLIP_POS_W-1:0];
				REG_CLIP_TOP: top_q <= cfg_data[CLIP_POS_W-1:0];
				REG_CLIP_WIDTH: width_q <= cfg_data[CLIP_SIZE_W-1:0];
				REG_CLIP_HEIGHT: height_q <= cfg_data[CLIP_SIZE_W-1:0];
				REG_COLOR: color_q <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// scissor bounds
	coord_t left_c, right_c, top_c, bottom_c, ybot_c;
	assign left_c = coord_t'(left_q);
	assign right_c = left_c + coord_t'(width_q);
	assign top_c = coord_t'(top_q);
	assign bottom_c = top_c + coord_t'(height_q);
	assign ybot_c = bottom_c - coord_t'(1);

	// endpoints: point 0 doubles as the walker position, point 1 as the stop point
	coord_t x0_q, y0_q, x1_q, y1_q;
	coord_t dx_q, dy_q;
	err_t   err_q;
	logic   neg_x_q, neg_y_q, major_x_q, busy_q;

	coord_t minx, maxx, miny, maxy;
	assign minx = (x0_q < x1_q) ? x0_q : x1_q;
	assign maxx = (x0_q < x1_q) ? x1_q : x0_q;
	assign miny = (y0_q < y1_q) ? y0_q : y1_q;
	assign maxy = (y0_q < y1_q) ? y1_q : y0_q;

	// clip k works on endpoint a (0 for k<2, else 1) toward b, row limit top or bottom
	logic   side_b;
	coord_t xa, ya, xb, yb, lim, dnum, tval, den;
	assign side_b = cmd.clip_k[1];
	assign xa = side_b ? x1_q : x0_q;
	assign ya = side_b ? y1_q : y0_q;
	assign xb = side_b ? x0_q : x1_q;
	assign yb = side_b ? y0_q : y1_q;
	assign lim = cmd.clip_k[0] ? ybot_c : top_c;
	assign dnum = xb - xa;
	assign tval = lim - ya;
	assign den = yb - ya;

	logic signed [PW-1:0] prod_s1;
	coord_t               den_s1;
	logic                 qneg_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= PW'(dnum) * PW'(tval);
			den_s1 <= den;
		end
	end

	// rounding bias den/2 truncated toward zero
	coord_t               half;
	logic signed [PW-1:0] num;
	logic [PW-1:0]        num_mag;
	coord_t               den_mag;
	assign half = (den_s1 + coord_t'(den_s1[CW-1])) >>> 1;
	assign num = prod_s1 + PW'(half);
	assign num_mag = num[PW-1] ? -num : num;
	assign den_mag = den_s1[CW-1] ? -den_s1 : den_s1;

	always_ff @(posedge clk) begin
		if (cmd.div_start) qneg_q <= num[PW-1] ^ den_s1[CW-1];
	end

	logic          div_busy;
	logic [PW-1:0] quo;

	clr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num_mag),
		.divisor  (den_mag),
		.busy     (div_busy),
		.quotient (quo)
	);

	coord_t qs;
	assign qs = qneg_q ? -coord_t'(quo[CW-1:0]) : coord_t'(quo[CW-1:0]);

	// line setup
	coord_t adx, ady, amaj;
	logic   fmaj;
	assign adx = (x1_q > x0_q) ? (x1_q - x0_q) : (x0_q - x1_q);
	assign ady = (y1_q > y0_q) ? (y1_q - y0_q) : (y0_q - y1_q);
	assign fmaj = (adx >= ady);
	assign amaj = fmaj ? adx : ady;

	// walker
	logic   we, fin;
	coord_t sx, sy;
	err_t   err_sub, minor_e, major_e;
	assign we = (x0_q >= left_c) && (x0_q < right_c);
	assign fin = (x0_q == x1_q) && (y0_q == y1_q);
	assign sx = neg_x_q ? -coord_t'(1) : coord_t'(1);
	assign sy = neg_y_q ? -coord_t'(1) : coord_t'(1);
	assign minor_e = major_x_q ? err_t'({1'b0, dy_q}) : err_t'({1'b0, dx_q});
	assign major_e = major_x_q ? err_t'({1'b0, dx_q}) : err_t'({1'b0, dy_q});
	assign err_sub = err_q - minor_e;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x0_q <= coord_t'(start_x) + coord_t'(ofs_h_q);
			y0_q <= coord_t'(start_y) + coord_t'(ofs_v_q);
			x1_q <= coord_t'(end_x) + coord_t'(ofs_h_q);
			y1_q <= coord_t'(end_y) + coord_t'(ofs_v_q);
		end else if (cmd.apply) begin
			if (side_b) begin
				x1_q <= x1_q + qs;
				y1_q <= lim;
			end else begin
				x0_q <= x0_q + qs;
				y0_q <= lim;
			end
		end else if (cmd.finish) begin
			dx_q <= adx;
			dy_q <= ady;
			neg_x_q <= !(x0_q < x1_q);
			neg_y_q <= !(y0_q < y1_q);
			major_x_q <= fmaj;
			err_q <= err_t'({1'b0, amaj}) >>> 1;
		end else if (cmd.step && busy_q && !fin) begin
			if (major_x_q) x0_q <= x0_q + sx;
			else y0_q <= y0_q + sy;
			if (err_sub[EW-1]) begin
				if (major_x_q) y0_q <= y0_q + sy;
				else x0_q <= x0_q + sx;
				err_q <= err_sub + major_e;
			end else begin
				err_q <= err_sub;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd.reject) begin
			busy_q <= 1'b0;
		end else if (cmd.finish) begin
			busy_q <= 1'b1;
		end else if (cmd.step && busy_q && fin) begin
			busy_q <= 1'b0;
		end
	end

	// output register
	logic               out_valid_q, out_active_q, out_we_q, out_last_q;
	logic [PIX_W-1:0]   out_x_q, out_y_q;
	logic [COLOR_W-1:0] out_val_q;
	logic               emit, out_free;

	assign out_free = !out_valid_q || out_ready;
	assign emit = cmd.step || cmd.reject || cmd.finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (emit) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_active_q <= cmd.finish || (cmd.step && busy_q);
			out_we_q <= 1'b0;
			out_x_q <= '0;
			out_y_q <= '0;
			out_val_q <= '0;
			out_last_q <= 1'b0;
			if (cmd.step && busy_q) begin
				out_we_q <= we;
				out_x_q <= we ? x0_q[PIX_W-1:0] : '0;
				out_y_q <= y0_q[PIX_W-1:0];
				out_val_q <= we ? color_q : '0;
				out_last_q <= fin;
			end
		end
	end

	always_comb begin
		stat.box_reject = (width_q == '0) || (height_q == '0) || (maxx < left_c) ||
			(minx >= right_c) || (maxy < top_c) || (miny >= bottom_c);
		stat.horiz = (y0_q == y1_q);
		stat.clip_cond = cmd.clip_k[0] ? (ya > ybot_c) : (ya < top_c);
		stat.clip_reject = !cmd.clip_k[1] && (cmd.clip_k[0] ? (yb > ybot_c) : (yb < top_c));
		stat.div_done = !div_busy;
		stat.out_free = out_free;
	end

	assign out_valid = out_valid_q;
	assign line_active = out_active_q;
	assign write_enable = out_we_q;
	assign pixel_x = out_x_q;
	assign pixel_y = out_y_q;
	assign pixel_value = out_val_q;
	assign last = out_last_q;

endmodule
`default_nettype wire

FILE: rtl/clipped_line_rasterizer_top.sv
// Clipped Bresenham line rasterizer.
// Input stream: s_tuser selects the beat kind (0 loads a line, 1 steps one pixel);
// s_tdata carries the endpoints, used on loads only. Configuration is written through
// cfg_we / cfg_index / cfg_data; the user must do so only while no beat is in flight,
// as the block does not enforce it. Every input beat yields exactly one output beat.
// m_tuser says whether a line is active and whether the pixel is inside the scissor
// columns; m_tlast marks the end point. A step beat's result is registered at its
// accepting edge and is valid the next cycle, so steps run at one pixel per cycle while
// the output is drained. A load runs a sequencer: offset, bounding box test, then up to
// two endpoint row clips, each a multiply plus a shift-subtract divide; a horizontal
// line skips the clips. s_tready stays low while a load is being worked on.
// Reset clears the configuration to zero, drops any line and empties the output register.
// When m_tready is low the finished beat waits in the output register and s_tready
// drops until it is taken; nothing is lost.
`default_nettype none
module clipped_line_rasterizer_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// start_x, start_y, end_x, end_y
	input  wire logic [clr_pkg::IN_TDATA_W-1:0]    s_tdata,
	// action
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// pixel_x, pixel_y, pixel_value, zero pad
	output logic [clr_pkg::OUT_TDATA_W-1:0]        m_tdata,
	// line_active, write_enable
	output logic [1:0]                             m_tuser,
	output logic                                   m_tlast,
	input  wire logic                              cfg_we,
	input  wire logic [clr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [clr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import clr_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;
	logic ctrl_idle, in_accept;
	logic line_active, write_enable;
	logic [PIX_W-1:0] pixel_x, pixel_y;
	logic [COLOR_W-1:0] pixel_value;

	assign s_tready = ctrl_idle && stat.out_free;
	assign in_accept = s_tvalid && s_tready;

	clr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_action (s_tuser),
		.stat      (stat),
		.cmd       (cmd),
		.idle      (ctrl_idle)
	);

	clr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.start_x      (signed'(s_tdata[COORD_BITS-1:0])),
		.start_y      (signed'(s_tdata[2*COORD_BITS-1:COORD_BITS])),
		.end_x        (signed'(s_tdata[3*COORD_BITS-1:2*COORD_BITS])),
		.end_y        (signed'(s_tdata[4*COORD_BITS-1:3*COORD_BITS])),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.line_active  (line_active),
		.write_enable (write_enable),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_value  (pixel_value),
		.last         (m_tlast)
	);

	assign m_tdata = OUT_TDATA_W'({pixel_value, pixel_y, pixel_x});
	assign m_tuser = {write_enable, line_active};

	// a load beat closes the input until its result is built
	a_load_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && s_tuser == ACT_LOAD) |=> !s_tready)
		else $error("input open right after a load beat");

	// input is only open when the output register can take the result
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("input open while output is stalled");

	// a step beat produces its result on the next edge
	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && s_tuser == ACT_STEP) |=> m_tvalid)
		else $error("step beat without a result");

	// visible pixels and end points belong to an active line
	a_we_active: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[1] || m_tlast)) |-> m_tuser[0])
		else $error("pixel flags set without an active line");

endmodule
`default_nettype wire
